/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SIZE_BITS  = 24;
   localparam int LIMIT_W    = SIZE_BITS + 1;
   localparam int SUM_W      = SIZE_BITS + 2;
   localparam int ADDR_W     = 32;
   localparam int HDR_W      = 6;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_W      = 32;
   localparam int SPLIT_MIN  = 8;

   localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = LIMIT_W'(1) << SIZE_BITS;
   localparam logic [HDR_W-1:0]   HEADER_RST     = HDR_W'(12);

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER     = 2'd2;

   typedef struct packed {
      logic                 free;
      logic [SIZE_BITS-1:0] size;
      logic [SIZE_BITS-1:0] off;
   } entry_type;

   typedef enum logic [2:0] {
      WR_COPY,
      WR_USED_FULL,
      WR_USED_REQ,
      WR_SPLIT,
      WR_BUMP,
      WR_MERGED
   } wr_sel_type;

   typedef enum logic [1:0] {
      HOLD_KEEP,
      HOLD_READ,
      HOLD_BUMP
   } hold_op_type;

   typedef enum logic [1:0] {
      ACC_KEEP,
      ACC_MERGE_PREV,
      ACC_MERGE_NEXT
   } acc_op_type;

   typedef struct packed {
      logic                load_req;
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      wr_sel_type          wr_sel;
      hold_op_type         hold_op;
      acc_op_type          acc_op;
      logic                cnt_inc;
      logic [1:0]          cnt_sub;
      logic                bump_adv;
      logic                out_load;
      logic [STATUS_W-1:0] out_status;
      logic                out_addr_en;
   } cmd_type;

   typedef struct packed {
      logic             kind;
      logic             req_zero;
      logic             addr_zero;
      logic [CNT_W-1:0] count;
      logic             fit;
      logic             match;
      logic             rd_free;
      logic             split_ok;
      logic             bump_ok;
   } sts_type;

endpackage

/* rtl/ffba_datapath.sv */
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, configuration, counters, arithmetic and result register.
// ----------------------------------------------------------------------------
module ffba_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [ffba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffba_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                              req_kind,
   input  logic [ffba_pkg::SIZE_BITS-1:0]    req_size,
   input  logic [ffba_pkg::ADDR_W-1:0]       req_addr,
   input  ffba_pkg::cmd_type                 cmd,
   output ffba_pkg::sts_type                 sts,
   output logic [ffba_pkg::ADDR_W-1:0]       rsp_payload,
   output logic [ffba_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int SB = ffba_pkg::SIZE_BITS;
   localparam int SW = ffba_pkg::SUM_W;
   localparam int AW = ffba_pkg::ADDR_W;
   localparam logic [SW-1:0] SIZE_MAX = SW'((64'd1 << SB) - 64'd1);
   localparam logic [ffba_pkg::LIMIT_W-1:0] SPAN = ffba_pkg::LIMIT_W'(1) << SB;

   logic [AW-1:0]                      base_ff;
   logic [ffba_pkg::LIMIT_W-1:0]       limit_ff;
   logic [ffba_pkg::HDR_W-1:0]         hdr_ff;
   logic [ffba_pkg::CNT_W-1:0]         count_ff;
   logic [ffba_pkg::LIMIT_W-1:0]       bump_ff;
   logic                               kind_ff;
   logic [SB-1:0]                      size_ff;
   logic [AW-1:0]                      addr_ff;
   ffba_pkg::entry_type                mem [ffba_pkg::MAX_BLOCKS];
   ffba_pkg::entry_type                rd_ff;
   ffba_pkg::entry_type                hold_ff;
   logic [SB-1:0]                      acc_ff;
   logic [SB-1:0]                      moff_ff;
   logic [AW-1:0]                      pay_ff;
   logic [ffba_pkg::STATUS_W-1:0]      stat_ff;

   ffba_pkg::entry_type                wdata;
   logic [SW-1:0]                      hdr_w;
   logic [SW-1:0]                      split_off;
   logic [SW-1:0]                      split_size;
   logic [SW-1:0]                      msum;
   logic [SB-1:0]                      msat;
   logic [SW-1:0]                      bump_sum;
   logic [ffba_pkg::LIMIT_W-1:0]       lim;
   logic [AW-1:0]                      hold_pay;
   logic [AW-1:0]                      rd_pay;

   assign hdr_w      = SW'(hdr_ff);
   assign split_off  = SW'(hold_ff.off) + hdr_w + SW'(size_ff);
   assign split_size = SW'(hold_ff.size) - hdr_w - SW'(size_ff);
   assign msum       = SW'(acc_ff) + hdr_w + SW'(rd_ff.size);
   assign msat       = (msum > SIZE_MAX) ? SIZE_MAX[SB-1:0] : msum[SB-1:0];
   assign bump_sum   = SW'(bump_ff) + hdr_w + SW'(size_ff);
   assign lim        = (limit_ff < SPAN) ? limit_ff : SPAN;
   assign hold_pay   = base_ff + AW'(hold_ff.off) + AW'(hdr_ff);
   assign rd_pay     = base_ff + AW'(rd_ff.off) + AW'(hdr_ff);

   always_comb begin
      wdata = rd_ff;
      case (cmd.wr_sel)
         ffba_pkg::WR_COPY:      wdata = rd_ff;
         ffba_pkg::WR_USED_FULL: wdata = '{free: 1'b0, size: hold_ff.size, off: hold_ff.off};
         ffba_pkg::WR_USED_REQ:  wdata = '{free: 1'b0, size: size_ff, off: hold_ff.off};
         ffba_pkg::WR_SPLIT:     wdata = '{free: 1'b1, size: split_size[SB-1:0],
                                           off: split_off[SB-1:0]};
         ffba_pkg::WR_BUMP:      wdata = '{free: 1'b0, size: size_ff, off: bump_ff[SB-1:0]};
         ffba_pkg::WR_MERGED:    wdata = '{free: 1'b1, size: acc_ff, off: moff_ff};
         default:                wdata = rd_ff;
      endcase
   end

   always_comb begin
      sts.kind      = kind_ff;
      sts.req_zero  = (size_ff == '0);
      sts.addr_zero = (addr_ff == '0);
      sts.count     = count_ff;
      sts.fit       = rd_ff.free && (rd_ff.size >= size_ff);
      sts.match     = (rd_pay == addr_ff);
      sts.rd_free   = rd_ff.free;
      sts.split_ok  = (SW'(hold_ff.size) >= SW'(size_ff) + hdr_w + SW'(ffba_pkg::SPLIT_MIN))
                      && (count_ff < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS));
      sts.bump_ok   = (count_ff < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
                      && (bump_sum <= SW'(lim));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         limit_ff <= ffba_pkg::HEAP_LIMIT_RST;
         hdr_ff   <= ffba_pkg::HEADER_RST;
         count_ff <= '0;
         bump_ff  <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               ffba_pkg::CSR_HEAP_BASE:  base_ff  <= csr_wdata[AW-1:0];
               ffba_pkg::CSR_HEAP_LIMIT: limit_ff <= csr_wdata[ffba_pkg::LIMIT_W-1:0];
               ffba_pkg::CSR_HEADER:     hdr_ff   <= csr_wdata[ffba_pkg::HDR_W-1:0];
               default: ;
            endcase
         end
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + 1'b1;
         end else begin
            count_ff <= count_ff - ffba_pkg::CNT_W'(cmd.cnt_sub);
         end
         if (cmd.bump_adv) begin
            bump_ff <= bump_sum[ffba_pkg::LIMIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         size_ff <= req_size;
         addr_ff <= req_addr;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wdata;
      end
      case (cmd.hold_op)
         ffba_pkg::HOLD_READ: begin
            hold_ff <= rd_ff;
            acc_ff  <= rd_ff.size;
            moff_ff <= rd_ff.off;
         end
         ffba_pkg::HOLD_BUMP: hold_ff <= '{free: 1'b0, size: size_ff, off: bump_ff[SB-1:0]};
         default: ;
      endcase
      case (cmd.acc_op)
         ffba_pkg::ACC_MERGE_PREV: begin
            acc_ff  <= msat;
            moff_ff <= rd_ff.off;
         end
         ffba_pkg::ACC_MERGE_NEXT: acc_ff <= msat;
         default: ;
      endcase
      if (cmd.out_load) begin
         pay_ff  <= cmd.out_addr_en ? hold_pay : '0;
         stat_ff <= cmd.out_status;
      end
   end

   assign rsp_payload = pay_ff;
   assign rsp_status  = stat_ff;

endmodule

/* rtl/ffba_control.sv */
// ----------------------------------------------------------------------------
// ffba_control
// Sequencer for table scan, split insertion, bump append, merge and removal.
// ----------------------------------------------------------------------------
module ffba_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  ffba_pkg::sts_type sts,
   output ffba_pkg::cmd_type cmd
);

   localparam int CW = ffba_pkg::CNT_W;
   localparam int IW = ffba_pkg::IDX_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_HIT, S_SHIFT_RD, S_SHIFT_WR,
      S_SPLIT_WR, S_SPLIT_WR2, S_BUMP, S_FREE_PREV, S_PREV_CHK, S_FREE_NEXT,
      S_NEXT_CHK, S_FREE_WR, S_RM_CHK, S_RM_WR, S_RESP
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 j_ff, j_in;
   logic [CW-1:0]                 mbase_ff, mbase_in;
   logic [1:0]                    k_ff, k_in;
   logic [ffba_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                          res_addr_ff, res_addr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                 idx_nx;
   logic [CW-1:0]                 rm_src;

   assign idx_nx = idx_ff + 1'b1;
   assign rm_src = j_ff + CW'(k_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      mbase_in      = mbase_ff;
      k_in          = k_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      cmd           = '0;
      cmd.wr_sel    = ffba_pkg::WR_COPY;
      cmd.hold_op   = ffba_pkg::HOLD_KEEP;
      cmd.acc_op    = ffba_pkg::ACC_KEEP;
      cmd.out_status  = res_status_ff;
      cmd.out_addr_en = res_addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            idx_in        = '0;
            res_status_in = ffba_pkg::ST_OK;
            res_addr_in   = 1'b0;
            if (!sts.kind && sts.req_zero) begin
               res_status_in = ffba_pkg::ST_ZERO;
               state_in      = S_RESP;
            end else if (sts.kind && sts.addr_zero) begin
               res_status_in = ffba_pkg::ST_NULL;
               state_in      = S_RESP;
            end else if (sts.count == '0) begin
               if (sts.kind) begin
                  res_status_in = ffba_pkg::ST_UNKNOWN;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_BUMP;
               end
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_ff[IW-1:0];
            state_in    = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (sts.kind ? sts.match : sts.fit) begin
               cmd.hold_op = ffba_pkg::HOLD_READ;
               state_in    = sts.kind ? S_FREE_PREV : S_ALLOC_HIT;
            end else begin
               idx_in = idx_nx;
               if (idx_nx == sts.count) begin
                  if (sts.kind) begin
                     res_status_in = ffba_pkg::ST_UNKNOWN;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_BUMP;
                  end
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_ALLOC_HIT: begin
            res_addr_in = 1'b1;
            if (sts.split_ok) begin
               j_in     = sts.count;
               state_in = (sts.count == idx_nx) ? S_SPLIT_WR : S_SHIFT_RD;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = idx_ff[IW-1:0];
               cmd.wr_sel  = ffba_pkg::WR_USED_FULL;
               state_in    = S_RESP;
            end
         end
         S_SHIFT_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = IW'(j_ff - 1'b1);
            state_in    = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = j_ff[IW-1:0];
            cmd.wr_sel  = ffba_pkg::WR_COPY;
            j_in        = j_ff - 1'b1;
            state_in    = ((j_ff - 1'b1) == idx_nx) ? S_SPLIT_WR : S_SHIFT_RD;
         end
         S_SPLIT_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = idx_nx[IW-1:0];
            cmd.wr_sel  = ffba_pkg::WR_SPLIT;
            state_in    = S_SPLIT_WR2;
         end
         S_SPLIT_WR2: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = idx_ff[IW-1:0];
            cmd.wr_sel  = ffba_pkg::WR_USED_REQ;
            cmd.cnt_inc = 1'b1;
            state_in    = S_RESP;
         end
         S_BUMP: begin
            if (sts.bump_ok) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_addr  = sts.count[IW-1:0];
               cmd.wr_sel   = ffba_pkg::WR_BUMP;
               cmd.hold_op  = ffba_pkg::HOLD_BUMP;
               cmd.cnt_inc  = 1'b1;
               cmd.bump_adv = 1'b1;
               res_addr_in  = 1'b1;
            end else begin
               res_status_in = ffba_pkg::ST_NO_SPACE;
            end
            state_in = S_RESP;
         end
         S_FREE_PREV: begin
            mbase_in = idx_ff;
            k_in     = '0;
            if (idx_ff != '0) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = IW'(idx_ff - 1'b1);
               state_in    = S_PREV_CHK;
            end else begin
               state_in = S_FREE_NEXT;
            end
         end
         S_PREV_CHK: begin
            if (sts.rd_free) begin
               cmd.acc_op = ffba_pkg::ACC_MERGE_PREV;
               mbase_in   = idx_ff - 1'b1;
               k_in       = 2'd1;
            end
            state_in = S_FREE_NEXT;
         end
         S_FREE_NEXT: begin
            if (idx_nx < sts.count) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = idx_nx[IW-1:0];
               state_in    = S_NEXT_CHK;
            end else begin
               state_in = S_FREE_WR;
            end
         end
         S_NEXT_CHK: begin
            if (sts.rd_free) begin
               cmd.acc_op = ffba_pkg::ACC_MERGE_NEXT;
               k_in       = k_ff + 1'b1;
            end
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = mbase_ff[IW-1:0];
            cmd.wr_sel  = ffba_pkg::WR_MERGED;
            j_in        = mbase_ff + 1'b1;
            state_in    = (k_ff == '0) ? S_RESP : S_RM_CHK;
         end
         S_RM_CHK: begin
            if (rm_src < sts.count) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = rm_src[IW-1:0];
               state_in    = S_RM_WR;
            end else begin
               cmd.cnt_sub = k_ff;
               state_in    = S_RESP;
            end
         end
         S_RM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = j_ff[IW-1:0];
            cmd.wr_sel  = ffba_pkg::WR_COPY;
            j_in        = j_ff + 1'b1;
            state_in    = S_RM_CHK;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         j_ff          <= '0;
         mbase_ff      <= '0;
         k_ff          <= '0;
         res_status_ff <= ffba_pkg::ST_OK;
         res_addr_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         j_ff          <= j_in;
         mbase_ff      <= mbase_in;
         k_ff          <= k_in;
         res_status_ff <= res_status_in;
         res_addr_ff   <= res_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sts.count <= CW'(ffba_pkg::MAX_BLOCKS))
      else $error("block count above table depth");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transaction");

   a_rm_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RM_WR) |-> (rm_src < sts.count))
      else $error("removal source beyond table");

   a_split_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT_WR2) |-> (sts.count < CW'(ffba_pkg::MAX_BLOCKS)))
      else $error("split on full table");

endmodule

/* rtl/first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap block allocator with split, bump append and free coalescing.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_      in         tuser: kind; tdata: request_size, release_address
//  rsp_      out        tdata: payload_address, status
//  csr_      in         write enable, index, data
//
//  Scan reads table entries one at a time, a read state then a check state each.
//  Split insert and merge removal move entries one at a time, read then write.
//  Requests are taken only in the idle state, one transaction at a time.
//  Reset is synchronous; the table needs no clearing after reset.
//  A pending result stalls the block only when the next one is ready.
module first_fit_block_allocator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [55:0]                        req_tdata,  // request_size, release_address
   input  logic                               req_tuser,  // kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,  // payload_address, status, zero pad
   input  logic                               csr_wen,
   input  logic [ffba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ffba_pkg::CSR_W-1:0]         csr_wdata
);

   ffba_pkg::cmd_type              cmd;
   ffba_pkg::sts_type              sts;
   logic [ffba_pkg::ADDR_W-1:0]    payload;
   logic [ffba_pkg::STATUS_W-1:0]  status;

   ffba_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_kind    (req_tuser),
      .req_size    (req_tdata[23:0]),
      .req_addr    (req_tdata[55:24]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (payload),
      .rsp_status  (status)
   );

   assign rsp_tdata = {5'b0, status, payload};

endmodule

/* verif/tb_first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_unit
// Self-checking bench: directed table then random allocate/free traffic over
// several register configurations, checked against an internal table predictor.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_unit;

   localparam bit KIND_ALLOC = 1'b0;
   localparam bit KIND_FREE  = 1'b1;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_WAIT = 300;
   localparam longint SIZE_MASK = (64'd1 << ffba_pkg::SIZE_BITS) - 1;

   typedef struct {
      bit          kind;
      logic [23:0] size;
      logic [31:0] addr;
      bit          typed;
      logic [31:0] pa;
      logic [2:0]  st;
   } op_row_type;

   typedef struct {
      logic [31:0] pa;
      logic [2:0]  st;
   } result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // request_size, release_address
   logic        req_tuser;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // payload_address, status, zero pad
   logic        csr_wen;
   logic [ffba_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ffba_pkg::CSR_W-1:0]     csr_wdata;

   first_fit_block_allocator_unit DUT (.*);

   always #5 clock = ~clock;

   // predictor state
   longint blk_off [ffba_pkg::MAX_BLOCKS];
   longint blk_size[ffba_pkg::MAX_BLOCKS];
   bit     blk_free[ffba_pkg::MAX_BLOCKS];
   int     blk_count;
   longint bump_top;
   longint cfg_base, cfg_limit, cfg_header;

   result_type    expected_q[$];
   op_row_type    typed_q[$];
   logic [31:0]   live_q[$];
   logic [31:0]   freed_q[$];

   int errors, mismatches, idle_cycles;
   int n_alloc_ok, n_no_space, n_free_ok, n_unknown, n_results;
   int gap_max;
   bit hold_long;

   op_row_type dir_rows[18] = '{
      '{KIND_ALLOC, 24'd0,       32'd0,         1'b1, 32'd0,  ffba_pkg::ST_ZERO},
      '{KIND_FREE,  24'd0,       32'd0,         1'b1, 32'd0,  ffba_pkg::ST_NULL},
      '{KIND_FREE,  24'd0,       32'hFFFF_FFFF, 1'b1, 32'd0,  ffba_pkg::ST_UNKNOWN},
      '{KIND_ALLOC, 24'hFF_FFFF, 32'd0,         1'b1, 32'd0,  ffba_pkg::ST_NO_SPACE},
      '{KIND_ALLOC, 24'd1,       32'd0,         1'b1, 32'd12, ffba_pkg::ST_OK},
      '{KIND_ALLOC, 24'd100,     32'd0,         1'b1, 32'd25, ffba_pkg::ST_OK},
      '{KIND_FREE,  24'd0,       32'd12,        1'b1, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_ALLOC, 24'd1,       32'd0,         1'b1, 32'd12, ffba_pkg::ST_OK},
      '{KIND_FREE,  24'd0,       32'd25,        1'b1, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_FREE,  24'd0,       32'd12,        1'b1, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_ALLOC, 24'd50,      32'd0,         1'b0, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_ALLOC, 24'd51,      32'd0,         1'b0, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_FREE,  24'd0,       32'd12,        1'b1, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_FREE,  24'd0,       32'd12,        1'b1, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_FREE,  24'd0,       32'd13,        1'b1, 32'd0,  ffba_pkg::ST_UNKNOWN},
      '{KIND_ALLOC, 24'h80_0000, 32'd0,         1'b0, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_FREE,  24'd0,       32'd74,        1'b0, 32'd0,  ffba_pkg::ST_OK},
      '{KIND_ALLOC, 24'd8,       32'd0,         1'b0, 32'd0,  ffba_pkg::ST_OK}
   };

   function automatic logic [31:0] blk_payload(int i);
      return 32'(cfg_base + blk_off[i] + cfg_header);
   endfunction

   function automatic void blk_insert(int i, longint off, longint sz, bit fr);
      for (int j = blk_count; j > i; j--) begin
         blk_off[j] = blk_off[j-1];
         blk_size[j] = blk_size[j-1];
         blk_free[j] = blk_free[j-1];
      end
      blk_off[i] = off & SIZE_MASK;
      blk_size[i] = sz & SIZE_MASK;
      blk_free[i] = fr;
      blk_count++;
   endfunction

   function automatic void blk_coalesce();
      int i;
      longint s;
      i = 0;
      while (i + 1 < blk_count) begin
         if (blk_free[i] && blk_free[i+1]) begin
            s = blk_size[i] + cfg_header + blk_size[i+1];
            blk_size[i] = (s > SIZE_MASK) ? SIZE_MASK : s;
            for (int j = i + 1; j + 1 < blk_count; j++) begin
               blk_off[j] = blk_off[j+1];
               blk_size[j] = blk_size[j+1];
               blk_free[j] = blk_free[j+1];
            end
            blk_count--;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic result_type heap_step(bit kind, longint size, logic [31:0] addr);
      result_type r;
      longint lim;
      r.pa = '0;
      r.st = ffba_pkg::ST_OK;
      if (kind == KIND_ALLOC) begin
         if (size == 0) begin
            r.st = ffba_pkg::ST_ZERO;
            return r;
         end
         for (int i = 0; i < blk_count; i++) begin
            if (blk_free[i] && blk_size[i] >= size) begin
               blk_free[i] = 1'b0;
               if (blk_size[i] >= size + cfg_header + ffba_pkg::SPLIT_MIN &&
                   blk_count < ffba_pkg::MAX_BLOCKS) begin
                  blk_insert(i + 1, blk_off[i] + cfg_header + size,
                             blk_size[i] - cfg_header - size, 1'b1);
                  blk_size[i] = size;
               end
               r.pa = blk_payload(i);
               return r;
            end
         end
         lim = (cfg_limit < (SIZE_MASK + 1)) ? cfg_limit : (SIZE_MASK + 1);
         if (blk_count >= ffba_pkg::MAX_BLOCKS || bump_top + cfg_header + size > lim) begin
            r.st = ffba_pkg::ST_NO_SPACE;
            return r;
         end
         blk_insert(blk_count, bump_top, size, 1'b0);
         bump_top += cfg_header + size;
         r.pa = blk_payload(blk_count - 1);
         return r;
      end
      if (addr == 0) begin
         r.st = ffba_pkg::ST_NULL;
         return r;
      end
      for (int i = 0; i < blk_count; i++) begin
         if (blk_payload(i) == addr) begin
            blk_free[i] = 1'b1;
            blk_coalesce();
            return r;
         end
      end
      r.st = ffba_pkg::ST_UNKNOWN;
      return r;
   endfunction

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      result_type got, want;
      op_row_type t;
      if (!reset) begin
         if (csr_wen) begin
            case (csr_index)
               ffba_pkg::CSR_HEAP_BASE:  cfg_base = longint'(csr_wdata);
               ffba_pkg::CSR_HEAP_LIMIT:
                  cfg_limit = longint'(csr_wdata[ffba_pkg::LIMIT_W-1:0]);
               ffba_pkg::CSR_HEADER:
                  cfg_header = longint'(csr_wdata[ffba_pkg::HDR_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            got.pa = rsp_tdata[31:0];
            got.st = rsp_tdata[34:32];
            if (expected_q.size() == 0) begin
               errors++;
               $display("unexpected transaction: addr %h status %0d", got.pa, got.st);
            end else begin
               want = expected_q.pop_front();
               if (got.pa !== want.pa || got.st !== want.st || rsp_tdata[39:35] !== '0)
               begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                              want.pa, want.st, got.pa, got.st);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            t = typed_q.pop_front();
            want = heap_step(req_tuser, longint'(req_tdata[23:0]), req_tdata[55:24]);
            if (req_tuser == KIND_ALLOC && want.st == ffba_pkg::ST_OK) begin
               live_q.push_back(want.pa);
               n_alloc_ok++;
            end
            if (want.st == ffba_pkg::ST_NO_SPACE) n_no_space++;
            if (want.st == ffba_pkg::ST_UNKNOWN) n_unknown++;
            if (req_tuser == KIND_FREE && want.st == ffba_pkg::ST_OK) n_free_ok++;
            if (t.typed) begin
               want.pa = t.pa;
               want.st = t.st;
            end
            expected_q.push_back(want);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
               $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

   // result side
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      forever begin
         if (hold_long) begin
            stall = 1500;
            hold_long = 1'b0;
         end else begin
            stall = $urandom_range(0, gap_max);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_op(op_row_type op);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_q.push_back(op);
      req_tvalid <= 1'b1;
      req_tuser <= op.kind;
      req_tdata <= {op.addr, op.size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [ffba_pkg::CSR_IDX_W-1:0] idx,
                            logic [ffba_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic random_ops(int count, int alloc_pct);
      op_row_type op;
      int r, k;
      for (int n = 0; n < count; n++) begin
         op.typed = 1'b0;
         op.pa = '0;
         op.st = ffba_pkg::ST_OK;
         op.size = 24'($urandom);
         op.addr = $urandom;
         r = $urandom_range(0, 99);
         if (r < alloc_pct || (r < 85 && live_q.size() == 0)) begin
            op.kind = KIND_ALLOC;
            k = $urandom_range(0, 99);
            if (k < 4) op.size = '0;
            else if (k < 10) op.size = 24'($urandom);
            else if (k < 14) op.size = 24'($urandom_range(1, 4096));
            else op.size = 24'($urandom_range(1, 64));
         end else begin
            op.kind = KIND_FREE;
            if (r < 85) begin
               k = $urandom_range(0, live_q.size() - 1);
               op.addr = live_q[k];
               live_q.delete(k);
               freed_q.push_back(op.addr);
            end else if (r < 89) begin
               op.addr = '0;
            end else if (r < 93 && freed_q.size() > 0) begin
               op.addr = freed_q[$urandom_range(0, freed_q.size() - 1)];
            end
         end
         send_op(op);
      end
   endtask

   initial begin
      errors = 0; mismatches = 0; idle_cycles = 0; n_results = 0;
      n_alloc_ok = 0; n_no_space = 0; n_free_ok = 0; n_unknown = 0;
      gap_max = 15;
      hold_long = 1'b0;
      cfg_base = 0; cfg_limit = 64'd1 << ffba_pkg::SIZE_BITS; cfg_header = 12;
      blk_count = 0; bump_top = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= 1'b0;
      req_tdata <= '0;
      csr_wen <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_op(dir_rows[i]);
      random_ops(100, 55);
      drain();

      csr_write(ffba_pkg::CSR_HEAP_BASE, 32'hFFFF_FFFF);
      csr_write(ffba_pkg::CSR_HEADER, 32'd32);
      csr_write(ffba_pkg::CSR_HEAP_LIMIT, 32'h01FF_FFFF);
      gap_max = 0;
      random_ops(120, 50);
      drain();

      csr_write(ffba_pkg::CSR_HEAP_BASE, $urandom);
      csr_write(ffba_pkg::CSR_HEADER, 32'd4);
      csr_write(ffba_pkg::CSR_HEAP_LIMIT, 32'd0);
      gap_max = 15;
      random_ops(30, 50);
      hold_long = 1'b1;
      gap_max = 0;
      random_ops(20, 50);
      gap_max = 15;
      random_ops(50, 50);
      drain();

      csr_write(ffba_pkg::CSR_HEAP_BASE, $urandom);
      csr_write(ffba_pkg::CSR_HEADER, 32'd17);
      csr_write(ffba_pkg::CSR_HEAP_LIMIT, 32'd16777216);
      random_ops(150, 80);
      drain();

      csr_write(ffba_pkg::CSR_HEAP_BASE, 32'd0);
      csr_write(ffba_pkg::CSR_HEADER, 32'd12);
      csr_write(ffba_pkg::CSR_HEAP_LIMIT, 32'd600);
      random_ops(130, 45);
      drain();

      if (expected_q.size() != 0) begin
         errors++;
         $display("%0d expected results never arrived", expected_q.size());
      end
      $display("%0d results checked: %0d grants, %0d out of space, %0d frees, %0d unknown",
               n_results, n_alloc_ok, n_no_space, n_free_ok, n_unknown);
      $display("covered header 4..32, base 0/max/random, limit 0/600/full, long result stall");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors (%0d mismatches)", errors, mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
